// ===== rtl/core/afrr_pkg.sv =====
// ----------------------------------------------------------------------------
// afrr_pkg
// Shared constants and types for the affine fit residual RMS block.
// ----------------------------------------------------------------------------
package afrr_pkg;

  localparam int unsigned CoefW = 32;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_A = 3'd0,
    REG_COEF_B = 3'd1,
    REG_COEF_C = 3'd2,
    REG_COEF_D = 3'd3,
    REG_COEF_E = 3'd4,
    REG_COEF_F = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] GainOne = 32'h0100_0000;
  localparam logic [63:0] MeanCap = 64'h0000_4000_0000_0000;

  // Start request and finish status between the top level and the finisher.
  typedef struct packed {
    logic        start;
    logic [63:0] sum_x;
    logic [63:0] sum_y;
    logic [16:0] count;
  } fin_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
  } fin_stat_t;

endpackage

// ===== rtl/core/afrr_finish.sv =====
// ----------------------------------------------------------------------------
// afrr_finish
// End of set: restoring divides of both sums by the count, then bit-pair
// square roots of the x, y and total means, all on one shared subtractor.
// ----------------------------------------------------------------------------
module afrr_finish (
  input  logic                clk,
  input  logic                rst,
  input  afrr_pkg::fin_req_t  req,
  output afrr_pkg::fin_stat_t stat,
  output logic [30:0]         rms_x,
  output logic [30:0]         rms_y,
  output logic [31:0]         rms_total
);
  import afrr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CLAMP, S_ROOT, S_DONE
  } state_t;

  state_t      state;
  logic [1:0]  sel;       // 0: x, 1: y, 2: total
  logic [6:0]  step;
  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] num_y;
  logic [16:0] den;
  logic [63:0] mean_x;
  logic [63:0] mean_y;
  logic [63:0] rrem;      // root remainder, up to 64 bits
  logic [63:0] root;
  logic [63:0] rbit;

  // Shared subtract: one divide step or one root step a cycle.
  logic [64:0] div_trial;
  logic [63:0] rt_trial;
  logic [64:0] sub_a;
  logic [64:0] sub_b;
  logic [64:0] sub_d;
  logic        sub_ok;

  always_comb begin
    div_trial = {rem, quo[63]};
    rt_trial  = root + rbit;
    if (state == S_DIV) begin
      sub_a = div_trial;
      sub_b = {48'd0, den};
    end else begin
      sub_a = {1'b0, rrem};
      sub_b = {1'b0, rt_trial};
    end
    sub_d  = sub_a - sub_b;
    sub_ok = !sub_d[64];
  end

  logic [63:0] cx;
  logic [63:0] cy;
  logic [63:0] root_arg;
  always_comb begin
    cx = (mean_x > MeanCap) ? MeanCap : mean_x;
    cy = (mean_y > MeanCap) ? MeanCap : mean_y;
    unique case (sel)
      2'd0:    root_arg = {cx[47:0], 16'd0};
      2'd1:    root_arg = {cy[47:0], 16'd0};
      default: root_arg = {cx[47:0] + cy[47:0], 16'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= '0;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            quo   <= req.sum_x;
            num_y <= req.sum_y;
            rem   <= '0;
            den   <= (req.count == 17'd0) ? 17'd1 : req.count;
            sel   <= 2'd0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == 7'd63) begin
            step <= '0;
            rem  <= '0;
            if (sel == 2'd0) begin
              mean_x <= {quo[62:0], sub_ok};
              quo    <= num_y;
              sel    <= 2'd1;
            end else begin
              mean_y <= {quo[62:0], sub_ok};
              quo    <= {quo[62:0], sub_ok};
              sel    <= 2'd0;
              state  <= S_CLAMP;
            end
          end else begin
            rem  <= sub_ok ? sub_d[63:0] : div_trial[63:0];
            quo  <= {quo[62:0], sub_ok};
            step <= step + 7'd1;
          end
        end
        S_CLAMP: begin
          rrem  <= root_arg;
          root  <= '0;
          rbit  <= 64'h4000_0000_0000_0000;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sub_ok) begin
            rrem <= sub_d[63:0];
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          if (rbit[0]) begin
            unique case (sel)
              2'd0: rms_x <= (sub_ok ? ((root >> 1) + rbit) : (root >> 1)) > 64'h7FFF_FFFF
                             ? 31'h7FFF_FFFF
                             : 31'(sub_ok ? ((root >> 1) + rbit) : (root >> 1));
              2'd1: rms_y <= (sub_ok ? ((root >> 1) + rbit) : (root >> 1)) > 64'h7FFF_FFFF
                             ? 31'h7FFF_FFFF
                             : 31'(sub_ok ? ((root >> 1) + rbit) : (root >> 1));
              default: rms_total <= 32'(sub_ok ? ((root >> 1) + rbit) : (root >> 1));
            endcase
            if (sel == 2'd2) begin
              state <= S_DONE;
            end else begin
              sel   <= sel + 2'd1;
              state <= S_CLAMP;
            end
          end
        end
        S_DONE: begin
          sel   <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);

  property p_start_idle;
    @(posedge clk) disable iff (rst) (req.start && state == S_IDLE) |=> state == S_DIV;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("finish did not start");

  property p_done_one;
    @(posedge clk) disable iff (rst) stat.done |=> !stat.done;
  endproperty
  a_done_one: assert property (p_done_one) else $error("done held twice");

  property p_sel_range;
    @(posedge clk) disable iff (rst) sel != 2'd3;
  endproperty
  a_sel_range: assert property (p_sel_range) else $error("bad select");

endmodule

// ===== rtl/core/affine_fit_residual_rms_top.sv =====
// ----------------------------------------------------------------------------
// affine_fit_residual_rms_top
// Affine prediction of measured points with residual RMS over a point set.
// ----------------------------------------------------------------------------
// An ordinary item runs through S_MUL, S_PRED, S_SQ and S_ACC to result valid;
// one shared 33x33 multiplier forms the four gain products and two squares.
// An item marked last adds two 64-step restoring divides and three 32-step
// square roots on one shared subtractor.
// One item is in work at a time; in_ready is low until the result is taken,
// so no new item is accepted before the last result has been taken.
// Synchronous reset restores the coefficients and clears sums and count.
// ----------------------------------------------------------------------------
module affine_fit_residual_rms_top #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] expected_x,
  input  logic [31:0] expected_y,
  input  logic [31:0] measured_x,
  input  logic [31:0] measured_y,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pred_x,
  output logic [31:0] pred_y,
  output logic        set_done,
  output logic [30:0] rms_x,
  output logic [30:0] rms_y,
  output logic [31:0] rms_total,
  output logic [12:0] point_count,
  output logic        overflow
);
  import afrr_pkg::*;

  // The count register holds up to MAX_POINTS itself.
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PRED, S_SQ, S_ACC, S_FIN, S_WAIT, S_OUT
  } state_t;

  logic [31:0] coef [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= '0;
      coef[1] <= GainOne;
      coef[2] <= '0;
      coef[3] <= '0;
      coef[4] <= '0;
      coef[5] <= GainOne;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_A: coef[0] <= cfg_data;
        REG_COEF_B: coef[1] <= cfg_data;
        REG_COEF_C: coef[2] <= cfg_data;
        REG_COEF_D: coef[3] <= cfg_data;
        REG_COEF_E: coef[4] <= cfg_data;
        REG_COEF_F: coef[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t      state;
  logic [2:0]  step;
  logic [31:0] ex, ey, mx, my;
  logic        lst;
  logic signed [63:0] prod [4];
  logic signed [31:0] px, py;
  logic signed [63:0] sqx, sqy;
  logic [63:0] sum_sq_x, sum_sq_y;
  logic [CntW-1:0] points_seen;
  logic        limit_exceeded;

  // The one shared multiplier: operands picked by the step counter.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [32:0] dx, dy;

  always_comb begin
    dx = $signed({ex[31], ex}) - $signed({px[31], px});
    dy = $signed({ey[31], ey}) - $signed({py[31], py});
    if (dx > 33'sd2147483647) dx = 33'sd2147483647;
    if (dx < -33'sd2147483648) dx = -33'sd2147483648;
    if (dy > 33'sd2147483647) dy = 33'sd2147483647;
    if (dy < -33'sd2147483648) dy = -33'sd2147483648;
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      case (step[1:0])
        2'd0: begin mul_a = $signed({coef[1][31], coef[1]}); mul_b = $signed({mx[31], mx}); end
        2'd1: begin mul_a = $signed({coef[2][31], coef[2]}); mul_b = $signed({my[31], my}); end
        2'd2: begin mul_a = $signed({coef[4][31], coef[4]}); mul_b = $signed({mx[31], mx}); end
        default: begin mul_a = $signed({coef[5][31], coef[5]}); mul_b = $signed({my[31], my}); end
      endcase
    end else if (step[0] == 1'b0) begin
      mul_a = dx;
      mul_b = dx;
    end else begin
      mul_a = dy;
      mul_b = dy;
    end
    mul_p = mul_a * mul_b;
  end

  // Floor shift of the summed products is exact; then offset and saturate.
  function automatic logic signed [31:0] affine_sat(input logic signed [63:0] p1,
                                                    input logic signed [63:0] p2,
                                                    input logic [31:0] off);
    logic signed [64:0] s;
    logic signed [65:0] t;
    s = $signed({p1[63], p1}) + $signed({p2[63], p2});
    t = $signed({{25{s[64]}}, s[64:24]}) + $signed({{34{off[31]}}, off});
    if (t > 66'sd2147483647) affine_sat = 32'sh7FFF_FFFF;
    else if (t < -66'sd2147483648) affine_sat = 32'sh8000_0000;
    else affine_sat = t[31:0];
  endfunction

  fin_req_t    freq;
  fin_stat_t   fstat;
  logic [30:0] f_rx, f_ry;
  logic [31:0] f_rt;
  logic [64:0] add_x, add_y;

  assign add_x = {1'b0, sum_sq_x} + {17'd0, sqx[63:16]};
  assign add_y = {1'b0, sum_sq_y} + {17'd0, sqy[63:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step           <= '0;
      sum_sq_x       <= '0;
      sum_sq_y       <= '0;
      points_seen    <= '0;
      limit_exceeded <= 1'b0;
      freq.start     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ex <= expected_x; ey <= expected_y;
            mx <= measured_x; my <= measured_y;
            lst   <= last;
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod[step[1:0]] <= mul_p[63:0];
          step <= step + 3'd1;
          if (step == 3'd3) state <= S_PRED;
        end
        S_PRED: begin
          px    <= affine_sat(prod[0], prod[1], coef[0]);
          py    <= affine_sat(prod[2], prod[3], coef[3]);
          step  <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (step[0] == 1'b0) sqx <= mul_p[63:0];
          else sqy <= mul_p[63:0];
          step <= step + 3'd1;
          if (step[0]) state <= S_ACC;
        end
        S_ACC: begin
          sum_sq_x <= add_x[64] ? '1 : add_x[63:0];
          sum_sq_y <= add_y[64] ? '1 : add_y[63:0];
          if (points_seen >= CntW'(MAX_POINTS)) limit_exceeded <= 1'b1;
          else points_seen <= points_seen + 1'b1;
          state <= lst ? S_FIN : S_OUT;
        end
        S_FIN: begin
          freq.start <= 1'b1;
          freq.sum_x <= sum_sq_x;
          freq.sum_y <= sum_sq_y;
          freq.count <= 17'(points_seen);
          state      <= S_WAIT;
        end
        S_WAIT: begin
          // The start request is a single-cycle pulse.
          freq.start <= 1'b0;
          if (fstat.done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
            if (lst) begin
              sum_sq_x       <= '0;
              sum_sq_y       <= '0;
              points_seen    <= '0;
              limit_exceeded <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  afrr_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .req       (freq),
    .stat      (fstat),
    .rms_x     (f_rx),
    .rms_y     (f_ry),
    .rms_total (f_rt)
  );

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign pred_x      = px;
  assign pred_y      = py;
  assign set_done    = lst;
  assign rms_x       = lst ? f_rx : '0;
  assign rms_y       = lst ? f_ry : '0;
  assign rms_total   = lst ? f_rt : '0;
  assign point_count = lst ? 13'(points_seen) : '0;
  assign overflow    = lst & limit_exceeded;

  property p_no_overlap;
    @(posedge clk) disable iff (rst) out_valid |-> !in_ready;
  endproperty
  a_no_overlap: assert property (p_no_overlap) else $error("ready while result held");

  property p_count_cap;
    @(posedge clk) disable iff (rst) points_seen <= CntW'(MAX_POINTS);
  endproperty
  a_count_cap: assert property (p_count_cap) else $error("count above limit");

  property p_fin_busy;
    @(posedge clk) disable iff (rst) state == S_WAIT |-> (fstat.busy || freq.start);
  endproperty
  a_fin_busy: assert property (p_fin_busy) else $error("finisher idle while waited on");

endmodule

// ===== sim/afrr_checker.sv =====
// ----------------------------------------------------------------------------
// afrr_checker
// Watches the configuration port and both item channels of the affine fit
// residual RMS block, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module afrr_checker
  import afrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] expected_x,
  input  logic [31:0] expected_y,
  input  logic [31:0] measured_x,
  input  logic [31:0] measured_y,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] pred_x,
  input  logic [31:0] pred_y,
  input  logic        set_done,
  input  logic [30:0] rms_x,
  input  logic [30:0] rms_y,
  input  logic [31:0] rms_total,
  input  logic [12:0] point_count,
  input  logic        overflow,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PointLimit = 4096;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic        done;
    logic [30:0] rx;
    logic [30:0] ry;
    logic [31:0] rt;
    logic [12:0] cnt;
    logic        ovf;
  } fit_result_t;

  logic signed [31:0] coef [6];
  logic [63:0]        acc_x, acc_y;
  int unsigned        npoints;
  logic               too_many;
  fit_result_t        expected_q [$];

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Exact Q.40 products, floored back to Q16.16, plus the offset.
  function automatic logic signed [31:0] affine_axis(
      logic signed [31:0] off, logic signed [31:0] g1, logic signed [31:0] m1,
      logic signed [31:0] g2, logic signed [31:0] m2);
    logic signed [65:0] a1, b1, a2, b2, o, s;
    a1 = g1; b1 = m1; a2 = g2; b2 = m2; o = off;
    s = a1 * b1 + a2 * b2;
    return clamp32((s >>> 24) + o);
  endfunction

  function automatic logic [63:0] residual_sq(logic signed [31:0] e,
                                              logic signed [31:0] p);
    logic signed [65:0] de, dp;
    logic signed [63:0] d, sq;
    de = e; dp = p;
    d = clamp32(de - dp);
    sq = d * d;
    return 64'(sq) >> 16;
  endfunction

  function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] rem, root, bitv;
    rem = x; root = 0; bitv = 64'd1 << 62;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic fit_result_t fit_point(logic signed [31:0] ex, logic signed [31:0] ey,
                                            logic signed [31:0] mx, logic signed [31:0] my,
                                            logic lst);
    fit_result_t r;
    logic [63:0] mean_x, mean_y, n, root_x, root_y, root_t;
    r = '0;
    r.px = affine_axis(coef[REG_COEF_A], coef[REG_COEF_B], mx, coef[REG_COEF_C], my);
    r.py = affine_axis(coef[REG_COEF_D], coef[REG_COEF_E], mx, coef[REG_COEF_F], my);
    acc_x = add_clip(acc_x, residual_sq(ex, r.px));
    acc_y = add_clip(acc_y, residual_sq(ey, r.py));
    if (npoints >= PointLimit) too_many = 1'b1;
    else npoints++;
    if (lst) begin
      n = (npoints != 0) ? 64'(npoints) : 64'd1;
      mean_x = acc_x / n;
      mean_y = acc_y / n;
      if (mean_x > MeanCap) mean_x = MeanCap;
      if (mean_y > MeanCap) mean_y = MeanCap;
      root_x = floor_root(mean_x << 16);
      root_y = floor_root(mean_y << 16);
      root_t = floor_root((mean_x + mean_y) << 16);
      // A capped mean gives a root one past the 31-bit field; it saturates.
      r.done = 1'b1;
      r.rx = (root_x > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : root_x[30:0];
      r.ry = (root_y > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : root_y[30:0];
      r.rt = (root_t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root_t[31:0];
      r.cnt = npoints[12:0];
      r.ovf = too_many;
      acc_x = 0; acc_y = 0; npoints = 0; too_many = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    fit_result_t got, want;
    if (rst) begin
      coef[REG_COEF_A] = '0;
      coef[REG_COEF_B] = GainOne;
      coef[REG_COEF_C] = '0;
      coef[REG_COEF_D] = '0;
      coef[REG_COEF_E] = '0;
      coef[REG_COEF_F] = GainOne;
      acc_x = 0; acc_y = 0; npoints = 0; too_many = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we && cfg_index <= REG_COEF_F) coef[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        expected_q.push_back(fit_point(expected_x, expected_y, measured_x, measured_y, last));
      if (out_valid && out_ready) begin
        got = '{pred_x, pred_y, set_done, rms_x, rms_y, rms_total, point_count, overflow};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result: %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.done !== want.done ||
              got.rx !== want.rx || got.ry !== want.ry || got.rt !== want.rt ||
              got.cnt !== want.cnt || got.ovf !== want.ovf) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch at %0t", $realtime);
              $display("  expected: %p", want);
              $display("  actual:   %p", got);
            end
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== sim/tb_affine_fit_residual_rms_top.sv =====
// ----------------------------------------------------------------------------
// tb_affine_fit_residual_rms_top
// Drives point sets through the affine fit residual RMS block under several
// coefficient settings and handshake idle patterns; the checker predicts and
// compares every result item.
// ----------------------------------------------------------------------------
module tb_affine_fit_residual_rms_top;
  import afrr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 300;   // Covers the divide and root tail of a last item.
  localparam int HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] expected_x = '0, expected_y = '0, measured_x = '0, measured_y = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pred_x, pred_y, rms_total;
  logic        set_done, overflow;
  logic [30:0] rms_x, rms_y;
  logic [12:0] point_count;
  int          errors, pending;

  // Idle percentages for each side, changed between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  affine_fit_residual_rms_top u_top (.*);

  afrr_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Global watchdog: a run that stops making progress ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver side. A hold request from the stimulus starts a long stretch in
  // which out_ready stays low; the stall is counted down here so that the
  // sender keeps offering items while the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offers one item; returns at the edge where it was accepted. Valid is only
  // lowered when an idle gap is actually taken, so it never drops between
  // back-to-back items.
  task automatic send_point(logic [31:0] ex, logic [31:0] ey, logic [31:0] mx,
                            logic [31:0] my, logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    expected_x <= ex;
    expected_y <= ey;
    measured_x <= mx;
    measured_y <= my;
    last <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  // The sender stops until every outstanding result has come back, then lets
  // the block finish any tail work before the next register write. The first
  // edge lets the checker count an item accepted at the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [31:0] e, logic [31:0] f);
    logic [31:0] vals [6];
    vals = '{a, b, c, d, e, f};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinates: full-range words, small values and the extremes, each a third
  // of the time, so that both saturating and ordinary predictions show up.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
      3: return 32'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    return GainOne + 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
  endfunction

  // Random point sets, mostly short so that many set results are checked.
  task automatic random_sets(int unsigned n_points);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_points) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int unsigned k = 1; k <= len; k++)
        send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(), k == len);
      sent += len;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients give the identity map: extremes and tiny sets.
    send_point('0, '0, '0, '0, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0001, 1'b1);
    drain();

    // Largest gains and offsets drive the predictions into saturation.
    load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_point('0, '0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    send_point('1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain();

    // A gain of minus one LSB checks the rounding toward minus infinity.
    load_coefs('0, 32'hFFFF_FFFF, 32'h0000_0001, '0, '0, '0);
    send_point('0, '0, 32'h0000_0001, 32'h0000_0001, 1'b0);
    send_point('0, '0, 32'h0100_0000, 32'hFF00_0000, 1'b0);
    send_point(32'h0000_0005, '0, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1);
    drain();

    // Random part: one coefficient setting and one idle pattern per phase.
    load_coefs($urandom_range(0, 32'hF_FFFF), pick_gain(), $urandom_range(0, 32'hF_FFFF),
               $urandom(), pick_gain(), pick_gain());
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    random_sets(260);
    drain();

    load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    send_idle_pct = 58;
    recv_stall_pct = 0;
    random_sets(260);
    drain();

    load_coefs(32'h8000_0000, pick_gain(), 32'h8000_0000, 32'h7FFF_FFFF, '0, 32'h7FFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    random_sets(260);
    drain();

    load_coefs($urandom(), pick_gain(), $urandom(), $urandom(), $urandom(), pick_gain());
    send_idle_pct = 8;
    recv_stall_pct = 8;
    hold_requests++;
    random_sets(260);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
